// ----- hw/rtl/rsc_pkg.sv -----
package rsc_pkg;

   localparam int MAX_COLUMNS = 32;
   localparam int MAX_ROWS    = 65536;

   localparam int WORD_W   = 32;
   localparam int IDX_W    = 21;
   localparam int COLCFG_W = 6;
   localparam int SEL_W    = 5;
   localparam int POS_W    = $clog2(MAX_COLUMNS);
   localparam int CNT_W    = $clog2(MAX_COLUMNS + 1);
   localparam int ADDR_W   = POS_W + 1;
   localparam int KEPT_W   = $clog2(MAX_ROWS + 1);
   localparam int CSR_W    = 2;

   typedef enum logic [CSR_W-1:0] {
      CSR_COLUMN_COUNT  = 2'd0,
      CSR_SELECT_COLUMN = 2'd1,
      CSR_THRESHOLD     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic              has_row;
      logic              has_count;
      logic              bank;
      logic [CNT_W-1:0]  cols;
      logic [IDX_W-1:0]  base;
      logic [KEPT_W-1:0] kept;
   } cmd_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } buf_wr_type;

   typedef struct packed {
      logic en;
      logic bank;
   } release_type;

endpackage

// ----- hw/rtl/rsc_front.sv -----
module rsc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [rsc_pkg::CSR_W-1:0]       csr_index,
   input  logic [rsc_pkg::WORD_W-1:0]      csr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [rsc_pkg::WORD_W-1:0] req_value,
   input  logic                            req_table_end,
   input  logic                            queue_full,
   output logic                            push_valid,
   output rsc_pkg::cmd_type                push_cmd,
   input  rsc_pkg::release_type            rel,
   output rsc_pkg::buf_wr_type             buf_wr
);

   logic [rsc_pkg::COLCFG_W-1:0]      cols_ff, cols_in;
   logic [rsc_pkg::SEL_W-1:0]         sel_ff, sel_in;
   logic signed [rsc_pkg::WORD_W-1:0] thr_ff, thr_in;
   logic [rsc_pkg::POS_W-1:0]         pos_ff, pos_in;
   logic                              selected_ff, selected_in;
   logic [rsc_pkg::KEPT_W-1:0]        kept_ff, kept_in;
   logic [rsc_pkg::IDX_W-1:0]         base_ff, base_in;
   logic                              bank_ff, bank_in;
   logic [1:0]                        busy_ff, busy_in;

   logic [rsc_pkg::CNT_W-1:0]  eff_cols;
   logic                       accept;
   logic                       sel_now;
   logic                       row_done;
   logic                       keep;
   logic [rsc_pkg::KEPT_W-1:0] kept_next;

   always_comb begin
      if (cols_ff == '0) begin
         eff_cols = rsc_pkg::CNT_W'(1);
      end else if (cols_ff > rsc_pkg::COLCFG_W'(rsc_pkg::MAX_COLUMNS)) begin
         eff_cols = rsc_pkg::CNT_W'(rsc_pkg::MAX_COLUMNS);
      end else begin
         eff_cols = rsc_pkg::CNT_W'(cols_ff);
      end
   end

   assign req_stall = queue_full || busy_ff[bank_ff];
   assign accept    = req_valid && !req_stall;
   assign sel_now   = (rsc_pkg::SEL_W'(pos_ff) == sel_ff) ? (req_value > thr_ff) : selected_ff;
   assign row_done  = (rsc_pkg::CNT_W'(pos_ff) + rsc_pkg::CNT_W'(1)) >= eff_cols;
   assign keep      = row_done && sel_now && (kept_ff < rsc_pkg::KEPT_W'(rsc_pkg::MAX_ROWS));
   assign kept_next = kept_ff + rsc_pkg::KEPT_W'(keep);

   assign push_valid         = accept && (keep || req_table_end);
   assign push_cmd.has_row   = keep;
   assign push_cmd.has_count = req_table_end;
   assign push_cmd.bank      = bank_ff;
   assign push_cmd.cols      = eff_cols;
   assign push_cmd.base      = base_ff;
   assign push_cmd.kept      = kept_next;

   assign buf_wr.en   = accept;
   assign buf_wr.addr = {bank_ff, pos_ff};
   assign buf_wr.data = req_value;

   always_comb begin
      cols_in = cols_ff;
      sel_in  = sel_ff;
      thr_in  = thr_ff;
      if (csr_write_en) begin
         case (csr_index)
            rsc_pkg::CSR_COLUMN_COUNT:  cols_in = csr_data[rsc_pkg::COLCFG_W-1:0];
            rsc_pkg::CSR_SELECT_COLUMN: sel_in  = csr_data[rsc_pkg::SEL_W-1:0];
            rsc_pkg::CSR_THRESHOLD:     thr_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      pos_in      = pos_ff;
      selected_in = selected_ff;
      kept_in     = kept_ff;
      base_in     = base_ff;
      bank_in     = bank_ff;
      busy_in     = busy_ff;
      if (rel.en) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (accept) begin
         pos_in      = row_done ? '0 : pos_ff + rsc_pkg::POS_W'(1);
         selected_in = row_done ? 1'b0 : sel_now;
         kept_in     = kept_next;
         if (keep) begin
            base_in          = base_ff + rsc_pkg::IDX_W'(eff_cols);
            bank_in          = ~bank_ff;
            busy_in[bank_ff] = 1'b1;
         end
         if (req_table_end) begin
            pos_in      = '0;
            selected_in = 1'b0;
            kept_in     = '0;
            base_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff     <= rsc_pkg::COLCFG_W'(1);
         sel_ff      <= '0;
         thr_ff      <= '0;
         pos_ff      <= '0;
         selected_ff <= 1'b0;
         kept_ff     <= '0;
         base_ff     <= '0;
         bank_ff     <= 1'b0;
         busy_ff     <= '0;
      end else begin
         cols_ff     <= cols_in;
         sel_ff      <= sel_in;
         thr_ff      <= thr_in;
         pos_ff      <= pos_in;
         selected_ff <= selected_in;
         kept_ff     <= kept_in;
         base_ff     <= base_in;
         bank_ff     <= bank_in;
         busy_ff     <= busy_in;
      end
   end

endmodule

// ----- hw/rtl/rsc_cmd_queue.sv -----
module rsc_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  rsc_pkg::cmd_type push_cmd,
   output logic             full,
   output logic             head_valid,
   output rsc_pkg::cmd_type head,
   input  logic             pop
);

   rsc_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       occ_ff, occ_in;

   assign full       = occ_ff == 2'd2;
   assign head_valid = occ_ff != 2'd0;
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      occ_in    = occ_ff + 2'(push_valid) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         occ_ff    <= occ_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) full |-> !push_valid || pop)
      else $error("command pushed into full queue");
   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("command popped from empty queue");

endmodule

// ----- hw/rtl/rsc_back.sv -----
module rsc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  rsc_pkg::buf_wr_type          buf_wr,
   input  logic                         head_valid,
   input  rsc_pkg::cmd_type             head,
   output logic                         pop,
   output rsc_pkg::release_type         rel,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_kind,
   output logic signed [rsc_pkg::WORD_W-1:0] rsp_value_res,
   output logic [rsc_pkg::IDX_W-1:0]    rsp_out_index,
   output logic                         rsp_run_last
);

   typedef struct packed {
      logic                      kind;
      logic [rsc_pkg::IDX_W-1:0] index;
      logic                      last;
      logic [rsc_pkg::WORD_W-1:0] value;
   } rsp_type;

   logic [rsc_pkg::WORD_W-1:0] row_mem [2*rsc_pkg::MAX_COLUMNS];
   logic [rsc_pkg::WORD_W-1:0] rd_data_ff;

   logic [rsc_pkg::CNT_W-1:0] word_ff, word_in;
   logic                      stg_valid_ff, stg_valid_in;
   rsp_type                   stg_ff, stg_in;
   rsp_type                   fifo_ff [2];
   rsp_type                   fifo_entry;
   logic                      head_ptr_ff, head_ptr_in;
   logic                      tail_ptr_ff, tail_ptr_in;
   logic [1:0]                occ_ff, occ_in;

   logic       out_pop;
   logic [2:0] fill_next;
   logic       room;
   logic       row_phase;
   logic       last_word;
   logic       issue;
   logic       issue_rd;
   logic       cmd_done;

   assign out_pop   = rsp_valid && !rsp_stall;
   assign fill_next = 3'(occ_ff) + 3'(stg_valid_ff) - 3'(out_pop);
   assign room      = fill_next < 3'd2;
   assign row_phase = head.has_row && (word_ff < head.cols);
   assign last_word = word_ff == (head.cols - rsc_pkg::CNT_W'(1));
   assign issue     = head_valid && room;
   assign issue_rd  = issue && row_phase;
   assign cmd_done  = issue && (row_phase ? (last_word && !head.has_count) : 1'b1);
   assign pop       = cmd_done;
   assign rel.en    = issue_rd && last_word;
   assign rel.bank  = head.bank;

   always_ff @(posedge clock) begin
      if (buf_wr.en) begin
         row_mem[buf_wr.addr] <= buf_wr.data;
      end
      if (issue_rd) begin
         rd_data_ff <= row_mem[{head.bank, word_ff[rsc_pkg::POS_W-1:0]}];
      end
   end

   always_comb begin
      word_in = word_ff;
      if (cmd_done) begin
         word_in = '0;
      end else if (issue) begin
         word_in = word_ff + rsc_pkg::CNT_W'(1);
      end
      stg_valid_in = issue;
      stg_in.kind  = !row_phase;
      stg_in.index = row_phase ? head.base + rsc_pkg::IDX_W'(word_ff) : '0;
      stg_in.last  = cmd_done;
      stg_in.value = rsc_pkg::WORD_W'(head.kept);
   end

   always_comb begin
      fifo_entry       = stg_ff;
      fifo_entry.value = stg_ff.kind ? stg_ff.value : rd_data_ff;
      tail_ptr_in      = stg_valid_ff ? ~tail_ptr_ff : tail_ptr_ff;
      head_ptr_in      = out_pop ? ~head_ptr_ff : head_ptr_ff;
      occ_in           = occ_ff + 2'(stg_valid_ff) - 2'(out_pop);
   end

   always_ff @(posedge clock) begin
      stg_ff <= stg_in;
      if (stg_valid_ff) begin
         fifo_ff[tail_ptr_ff] <= fifo_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff      <= '0;
         stg_valid_ff <= 1'b0;
         head_ptr_ff  <= 1'b0;
         tail_ptr_ff  <= 1'b0;
         occ_ff       <= '0;
      end else begin
         word_ff      <= word_in;
         stg_valid_ff <= stg_valid_in;
         head_ptr_ff  <= head_ptr_in;
         tail_ptr_ff  <= tail_ptr_in;
         occ_ff       <= occ_in;
      end
   end

   assign rsp_valid     = occ_ff != 2'd0;
   assign rsp_kind      = fifo_ff[head_ptr_ff].kind;
   assign rsp_value_res = fifo_ff[head_ptr_ff].value;
   assign rsp_out_index = fifo_ff[head_ptr_ff].index;
   assign rsp_run_last  = fifo_ff[head_ptr_ff].last;

   assert property (@(posedge clock) disable iff (reset) occ_ff != 2'd3)
      else $error("result buffer occupancy out of range");
   assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff && (occ_ff == 2'd2) |-> out_pop)
      else $error("result buffer overflow");
   assert property (@(posedge clock) disable iff (reset) cmd_done |=> word_ff == '0)
      else $error("word counter not cleared after command");
   assert property (@(posedge clock) disable iff (reset) rel.en |-> head.has_row)
      else $error("bank released by a command without a row");

endmodule

// ----- hw/rtl/row_select_compaction.sv -----
// Output path: after the transfer of its last input word, a kept row's words pass the
// command queue, the row-buffer read and staging registers and the result buffer; the count
// result follows the row words of the same transfer. Throughput: one input word per cycle, one
// result per cycle while rsp_stall is low; the two-bank row buffer lets a row fill while the
// previous kept row drains, input stalls when both banks are pending or the two-entry command
// queue is full. Reset: synchronous; returns row state, counters, queue pointers and settings to defaults.
module row_select_compaction (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [rsc_pkg::CSR_W-1:0]         csr_index,
   input  logic [rsc_pkg::WORD_W-1:0]        csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [rsc_pkg::WORD_W-1:0] req_value,
   input  logic                              req_table_end,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_kind,
   output logic signed [rsc_pkg::WORD_W-1:0] rsp_value_res,
   output logic [rsc_pkg::IDX_W-1:0]         rsp_out_index,
   output logic                              rsp_run_last
);

   logic                 push_valid;
   rsc_pkg::cmd_type     push_cmd;
   logic                 queue_full;
   logic                 head_valid;
   rsc_pkg::cmd_type     head;
   logic                 pop;
   rsc_pkg::release_type rel;
   rsc_pkg::buf_wr_type  buf_wr;

   rsc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .req_table_end (req_table_end),
      .queue_full    (queue_full),
      .push_valid    (push_valid),
      .push_cmd      (push_cmd),
      .rel           (rel),
      .buf_wr        (buf_wr)
   );

   rsc_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   rsc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .buf_wr        (buf_wr),
      .head_valid    (head_valid),
      .head          (head),
      .pop           (pop),
      .rel           (rel),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_value_res (rsp_value_res),
      .rsp_out_index (rsp_out_index),
      .rsp_run_last  (rsp_run_last)
   );

endmodule

// ----- verif/row_select_compaction_tb.sv -----
`timescale 1ns / 1ps

module row_select_compaction_tb;

   localparam int unsigned CYCLE_LIMIT   = 2_000_000;
   localparam int unsigned RANDOM_WORDS  = 430;
   localparam int unsigned SETTLE_CYCLES = 8;

   typedef struct packed {
      logic                       kind;
      logic [rsc_pkg::WORD_W-1:0] value;
      logic [rsc_pkg::IDX_W-1:0]  index;
      logic                       last;
   } out_beat_type;

   typedef struct {
      bit                           is_cfg;
      logic [rsc_pkg::WORD_W-1:0]   word;
      logic                         fin;
      bit                           typed;
      bit                           has_beat;
      out_beat_type                 beat;
      logic [rsc_pkg::COLCFG_W-1:0] cols;
      logic [rsc_pkg::SEL_W-1:0]    sel;
      logic [rsc_pkg::WORD_W-1:0]   thr;
   } script_row_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_SPARSE,
      STALL_PATTERN,
      STALL_HEAVY
   } stall_mode_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              csr_write_en;
   rsc_pkg::csr_index_type            csr_index;
   logic [rsc_pkg::WORD_W-1:0]        csr_data;
   logic                              req_valid;
   logic                              req_stall;
   logic signed [rsc_pkg::WORD_W-1:0] req_value;
   logic                              req_table_end;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic                              rsp_kind;
   logic signed [rsc_pkg::WORD_W-1:0] rsp_value_res;
   logic [rsc_pkg::IDX_W-1:0]         rsp_out_index;
   logic                              rsp_run_last;

   logic [rsc_pkg::COLCFG_W-1:0]      cfg_cols = rsc_pkg::COLCFG_W'(1);
   logic [rsc_pkg::SEL_W-1:0]         cfg_sel = '0;
   logic signed [rsc_pkg::WORD_W-1:0] cfg_thr = '0;
   logic [rsc_pkg::WORD_W-1:0]        row_store [rsc_pkg::MAX_COLUMNS];
   int unsigned                       col_pos = 0;
   bit                                row_hit = 1'b0;
   int unsigned                       kept_count = 0;
   logic [rsc_pkg::IDX_W-1:0]         base_index = '0;

   out_beat_type                      word_results[$];
   out_beat_type                      due_results[$];
   out_beat_type                      head;
   int unsigned                       mismatches = 0;
   int unsigned                       cycles = 0;
   int unsigned                       burst_left = 0;

   stall_mode_type                    stall_mode = STALL_NONE;
   int unsigned                       stall_hold = 0;
   logic [7:0]                        stall_mask = '0;
   logic [2:0]                        stall_phase = '0;

   row_select_compaction uut (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .req_table_end (req_table_end),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_value_res (rsp_value_res),
      .rsp_out_index (rsp_out_index),
      .rsp_run_last  (rsp_run_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned row_words();
      int unsigned n;
      n = cfg_cols;
      if (n == 0) n = 1;
      if (n > rsc_pkg::MAX_COLUMNS) n = rsc_pkg::MAX_COLUMNS;
      return n;
   endfunction

   function automatic void filter_word(logic signed [rsc_pkg::WORD_W-1:0] v, logic fin);
      int unsigned  n;
      int unsigned  pos;
      out_beat_type beat;
      n = row_words();
      pos = col_pos;
      word_results.delete();
      if (pos >= rsc_pkg::MAX_COLUMNS) pos = rsc_pkg::MAX_COLUMNS - 1;
      row_store[pos] = v;
      if (pos == cfg_sel) row_hit = (v > cfg_thr);
      if (pos + 1 >= n) begin
         if (row_hit && kept_count < rsc_pkg::MAX_ROWS) begin
            for (int unsigned k = 0; k < n; k++) begin
               word_results.push_back('{1'b0, row_store[k],
                                        base_index + rsc_pkg::IDX_W'(k), 1'b0});
            end
            kept_count++;
            base_index += rsc_pkg::IDX_W'(n);
         end
         col_pos = 0;
         row_hit = 1'b0;
      end else begin
         col_pos = pos + 1;
      end
      if (fin) begin
         word_results.push_back('{1'b1, rsc_pkg::WORD_W'(kept_count), '0, 1'b0});
         col_pos = 0;
         row_hit = 1'b0;
         kept_count = 0;
         base_index = '0;
      end
      if (word_results.size() != 0) begin
         beat = word_results.pop_back();
         beat.last = 1'b1;
         word_results.push_back(beat);
      end
   endfunction

   function automatic logic [rsc_pkg::WORD_W-1:0] pick_value(bit tested);
      int unsigned pick;
      pick = $urandom_range(0, 7);
      if (tested) begin
         case (pick)
            0: return cfg_thr;
            1: return cfg_thr + 1;
            2: return cfg_thr - 1;
            3: return 32'h7FFF_FFFF;
            4: return 32'h8000_0000;
            default: return $urandom;
         endcase
      end
      if (pick == 0) return 32'h7FFF_FFFF;
      if (pick == 1) return 32'h8000_0000;
      return $urandom;
   endfunction

   function automatic script_row_type cfg_row(logic [rsc_pkg::COLCFG_W-1:0] cols,
                                              logic [rsc_pkg::SEL_W-1:0] sel,
                                              logic [rsc_pkg::WORD_W-1:0] thr);
      script_row_type row;
      row = '{default: '0};
      row.is_cfg = 1'b1;
      row.cols = cols;
      row.sel = sel;
      row.thr = thr;
      return row;
   endfunction

   function automatic script_row_type open_row(logic [rsc_pkg::WORD_W-1:0] word, logic fin);
      script_row_type row;
      row = '{default: '0};
      row.word = word;
      row.fin = fin;
      return row;
   endfunction

   function automatic script_row_type quiet_row(logic [rsc_pkg::WORD_W-1:0] word, logic fin);
      script_row_type row;
      row = open_row(word, fin);
      row.typed = 1'b1;
      return row;
   endfunction

   function automatic script_row_type sure_row(logic [rsc_pkg::WORD_W-1:0] word, logic fin,
                                               logic kind, logic [rsc_pkg::WORD_W-1:0] value,
                                               logic [rsc_pkg::IDX_W-1:0] index);
      script_row_type row;
      row = quiet_row(word, fin);
      row.has_beat = 1'b1;
      row.beat = '{kind, value, index, 1'b1};
      return row;
   endfunction

   task automatic note_mismatch(input string what, input logic [rsc_pkg::WORD_W-1:0] got,
                                input logic [rsc_pkg::WORD_W-1:0] want);
      $display("mismatch in %s: got %h, expected %h", what, got, want);
      mismatches++;
   endtask

   task automatic drain(input bit settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (due_results.size() != 0);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [rsc_pkg::COLCFG_W-1:0] cols,
                                 input logic [rsc_pkg::SEL_W-1:0] sel,
                                 input logic [rsc_pkg::WORD_W-1:0] thr);
      drain(1'b1);
      csr_write_en <= 1'b1;
      csr_index <= rsc_pkg::CSR_COLUMN_COUNT;
      csr_data <= rsc_pkg::WORD_W'(cols);
      @(posedge clock);
      csr_index <= rsc_pkg::CSR_SELECT_COLUMN;
      csr_data <= rsc_pkg::WORD_W'(sel);
      @(posedge clock);
      csr_index <= rsc_pkg::CSR_THRESHOLD;
      csr_data <= thr;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_cols = cols;
      cfg_sel = sel;
      cfg_thr = thr;
   endtask

   task automatic send_item(input logic [rsc_pkg::WORD_W-1:0] v, input logic fin,
                            input bit typed);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_value <= v;
      req_table_end <= fin;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      filter_word(v, fin);
      if (!typed) foreach (word_results[i]) due_results.push_back(word_results[i]);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            note_mismatch("unexpected transfer", rsp_value_res, '0);
         end else begin
            head = due_results.pop_front();
            if (rsp_kind !== head.kind)
               note_mismatch("kind", rsc_pkg::WORD_W'(rsp_kind), rsc_pkg::WORD_W'(head.kind));
            if (rsp_value_res !== head.value) note_mismatch("value_res", rsp_value_res, head.value);
            if (rsp_out_index !== head.index)
               note_mismatch("out_index", rsc_pkg::WORD_W'(rsp_out_index),
                             rsc_pkg::WORD_W'(head.index));
            if (rsp_run_last !== head.last)
               note_mismatch("run_last", rsc_pkg::WORD_W'(rsp_run_last),
                             rsc_pkg::WORD_W'(head.last));
         end
      end
   end

   always @(posedge clock) begin
      if (stall_hold == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_mask <= 8'($urandom);
         stall_hold <= $urandom_range(32, 256);
      end else begin
         stall_hold <= stall_hold - 1;
      end
      stall_phase <= stall_phase + 3'd1;
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_SPARSE: rsp_stall <= ($urandom_range(0, 2) == 0);
         STALL_PATTERN: rsp_stall <= stall_mask[stall_phase];
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      script_row_type               script[$];
      int unsigned                  sent;
      int unsigned                  in_phase;
      int unsigned                  target;
      int unsigned                  phase_no;
      int unsigned                  shape;
      int unsigned                  rows;
      int unsigned                  n;
      int unsigned                  last_c;
      int unsigned                  len;
      logic [rsc_pkg::COLCFG_W-1:0] cols;
      logic [rsc_pkg::SEL_W-1:0]    sel;
      logic [rsc_pkg::WORD_W-1:0]   thr;
      logic                         stop;

      reset <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index <= rsc_pkg::CSR_COLUMN_COUNT;
      csr_data <= '0;
      req_valid <= 1'b0;
      req_value <= '0;
      req_table_end <= 1'b0;

      // one word per row, kept when above zero
      script.push_back(sure_row(32'h0000_0001, 1'b0, 1'b0, 32'h0000_0001, 21'd0));
      script.push_back(quiet_row(32'h0000_0000, 1'b0));
      script.push_back(sure_row(32'h7FFF_FFFF, 1'b0, 1'b0, 32'h7FFF_FFFF, 21'd1));
      script.push_back(quiet_row(32'h8000_0000, 1'b0));
      script.push_back(sure_row(32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0002, 21'd0));
      // zero column count behaves as one, threshold at its minimum
      script.push_back(cfg_row(6'd0, 5'd0, 32'h8000_0000));
      script.push_back(quiet_row(32'h8000_0000, 1'b0));
      script.push_back(sure_row(32'h8000_0001, 1'b0, 1'b0, 32'h8000_0001, 21'd0));
      // three-word rows tested on the last column, end of table on a kept row
      script.push_back(cfg_row(6'd3, 5'd2, 32'h7FFF_FFFE));
      script.push_back(open_row(32'h0000_000B, 1'b0));
      script.push_back(open_row(32'hFFFF_FFEA, 1'b0));
      script.push_back(open_row(32'h7FFF_FFFF, 1'b0));
      script.push_back(quiet_row(32'h0000_0001, 1'b0));
      script.push_back(quiet_row(32'h0000_0002, 1'b0));
      script.push_back(quiet_row(32'h7FFF_FFFE, 1'b0));
      script.push_back(open_row(32'h0000_0005, 1'b0));
      script.push_back(open_row(32'h0000_0006, 1'b0));
      script.push_back(open_row(32'h7FFF_FFFF, 1'b1));
      // partial final row dropped
      script.push_back(sure_row(32'h0000_0008, 1'b1, 1'b1, 32'h0000_0000, 21'd0));
      // select column outside the row
      script.push_back(cfg_row(6'd2, 5'd5, 32'h0000_0000));
      script.push_back(quiet_row(32'h0000_0009, 1'b0));
      script.push_back(sure_row(32'h0000_0009, 1'b1, 1'b1, 32'h0000_0000, 21'd0));
      // shorten the row while it is half filled
      script.push_back(cfg_row(6'd4, 5'd0, 32'h0000_0000));
      script.push_back(quiet_row(32'h0000_0003, 1'b0));
      script.push_back(quiet_row(32'h0000_0004, 1'b0));
      script.push_back(cfg_row(6'd2, 5'd0, 32'h0000_0000));
      script.push_back(open_row(32'h0000_0005, 1'b0));
      script.push_back(sure_row(32'h0000_0006, 1'b1, 1'b1, 32'h0000_0001, 21'd0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].is_cfg) begin
            apply_settings(script[i].cols, script[i].sel, script[i].thr);
         end else begin
            send_item(script[i].word, script[i].fin, script[i].typed);
            if (script[i].has_beat) due_results.push_back(script[i].beat);
         end
      end

      sent = 0;
      phase_no = 0;
      while (sent < RANDOM_WORDS) begin
         case (phase_no)
            0: begin
               cols = 6'd32;
               sel = 5'd31;
               thr = 32'h8000_0000;
            end
            1: begin
               cols = 6'd63;
               sel = 5'd0;
               thr = 32'h7FFF_FFFF;
            end
            2: begin
               cols = 6'd0;
               sel = 5'd0;
               thr = 32'hFFFF_FFFF;
            end
            3: begin
               cols = 6'd1;
               sel = 5'd5;
               thr = 32'h0000_0000;
            end
            default: begin
               shape = $urandom_range(0, 9);
               if (shape < 7) cols = rsc_pkg::COLCFG_W'($urandom_range(1, 6));
               else if (shape == 7) cols = rsc_pkg::COLCFG_W'($urandom_range(7, 32));
               else if (shape == 8) cols = 6'd0;
               else cols = rsc_pkg::COLCFG_W'($urandom_range(33, 63));
               n = (cols == 0) ? 1 :
                   ((cols > rsc_pkg::MAX_COLUMNS) ? rsc_pkg::MAX_COLUMNS : cols);
               if ($urandom_range(0, 4) == 0) sel = rsc_pkg::SEL_W'($urandom_range(0, 31));
               else sel = rsc_pkg::SEL_W'($urandom_range(0, n - 1));
               case ($urandom_range(0, 5))
                  0: thr = 32'h8000_0000;
                  1: thr = 32'h7FFF_FFFF;
                  2: thr = 32'h0000_0000;
                  3: thr = 32'hFFFF_FFFF;
                  default: thr = $urandom;
               endcase
            end
         endcase
         apply_settings(cols, sel, thr);
         phase_no++;
         n = row_words();
         target = $urandom_range(20, 60);
         in_phase = 0;
         while (in_phase < target) begin
            shape = $urandom_range(0, 9);
            if (shape == 0) begin
               len = $urandom_range(1, 2 * n + 1);
               for (int unsigned j = 0; j < len; j++) begin
                  stop = (j == len - 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 5) == 0);
                  send_item(pick_value(1'($urandom_range(0, 1))), stop, 1'b0);
                  sent++;
                  in_phase++;
               end
            end else begin
               rows = $urandom_range(1, (n > 8) ? 2 : 6);
               last_c = (shape == 1 && n > 1) ? $urandom_range(0, n - 2) : n - 1;
               for (int unsigned r = 0; r < rows; r++) begin
                  for (int unsigned c = 0; c < n; c++) begin
                     stop = (r == rows - 1) && (c == last_c);
                     send_item(pick_value(c == cfg_sel), stop, 1'b0);
                     sent++;
                     in_phase++;
                     if ($urandom_range(0, 63) == 0) drain(1'b0);
                     if (stop) break;
                  end
               end
            end
         end
      end

      drain(1'b1);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
